@@ rtl/rrur_pkg.sv @@
// ----------------------------------------------------------------------------
// rrur_pkg
// Shared types and constants for the round-robin ultrasonic ranger: payload
// structs, configuration register map, reset values and sequencer phases.
// ----------------------------------------------------------------------------
package rrur_pkg;

  // Field widths fixed by the interface
  localparam int ECHO_W   = 3;
  localparam int QSEL_W   = 2;
  localparam int TRIG_W   = 3;
  localparam int ACT_W    = 2;
  localparam int PHASE_W  = 2;
  localparam int DIST_W   = 13;
  localparam int AGE_W    = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 3'd5;

  localparam int TWIDTH_W = 8;
  localparam int TOUT_W   = 20;
  localparam int STALE_W  = 32;

  localparam logic [TWIDTH_W-1:0] RST_TRIGGER_WIDTH = 8'd10;
  localparam logic [TOUT_W-1:0]   RST_ECHO_TIMEOUT  = 20'd25000;
  localparam logic [TOUT_W-1:0]   RST_PING_DELAY    = 20'd10000;
  localparam logic [STALE_W-1:0]  RST_STALE_TIMEOUT = 32'd100000;
  localparam logic [DIST_W-1:0]   RST_MIN_DISTANCE  = 13'd32;
  localparam logic [DIST_W-1:0]   RST_MAX_DISTANCE  = 13'd6400;

  // Echo duration (us) to sixteenths of a cm: d = (dur * 281) >> 10
  localparam int DIST_MUL   = 281;
  localparam int DIST_MUL_W = 9;
  localparam int DIST_SHIFT = 10;

  // Sequencer phases
  typedef enum logic [PHASE_W-1:0] {
    PH_TRIG  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_DELAY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [ECHO_W-1:0] echo_levels;
    logic [QSEL_W-1:0] query_sensor;
  } tick_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_lines;
    logic [ACT_W-1:0]   active_sensor;
    logic [PHASE_W-1:0] phase;
    logic [DIST_W-1:0]  query_distance;
    logic               query_usable;
    logic [AGE_W-1:0]   query_age;
    logic               query_stale;
  } report_t;

  typedef struct packed {
    logic [TWIDTH_W-1:0] trigger_width_us;
    logic [TOUT_W-1:0]   echo_timeout_us;
    logic [TOUT_W-1:0]   inter_ping_delay_us;
    logic [STALE_W-1:0]  stale_timeout_us;
    logic [DIST_W-1:0]   min_distance_q4;
    logic [DIST_W-1:0]   max_distance_q4;
  } cfg_t;

endpackage

@@ rtl/rrur_cfg.sv @@
// ----------------------------------------------------------------------------
// rrur_cfg
// Configuration register file. Always ready; writes to unknown indexes are
// dropped.
// ----------------------------------------------------------------------------
module rrur_cfg
  import rrur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  // Register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_width_us    <= RST_TRIGGER_WIDTH;
      cfg.echo_timeout_us     <= RST_ECHO_TIMEOUT;
      cfg.inter_ping_delay_us <= RST_PING_DELAY;
      cfg.stale_timeout_us    <= RST_STALE_TIMEOUT;
      cfg.min_distance_q4     <= RST_MIN_DISTANCE;
      cfg.max_distance_q4     <= RST_MAX_DISTANCE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRIGGER_WIDTH: cfg.trigger_width_us    <= cfg_data[TWIDTH_W-1:0];
        CFG_ECHO_TIMEOUT:  cfg.echo_timeout_us     <= cfg_data[TOUT_W-1:0];
        CFG_PING_DELAY:    cfg.inter_ping_delay_us <= cfg_data[TOUT_W-1:0];
        CFG_STALE_TIMEOUT: cfg.stale_timeout_us    <= cfg_data[STALE_W-1:0];
        CFG_MIN_DISTANCE:  cfg.min_distance_q4     <= cfg_data[DIST_W-1:0];
        CFG_MAX_DISTANCE:  cfg.max_distance_q4     <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/rrur_core.sv @@
// ----------------------------------------------------------------------------
// rrur_core
// Per-tick ranging state: edge capture per sensor, trigger/wait/delay
// sequencer, distance conversion and query of the stored readings. All state
// advances once per step; the result is combinational from the current tick.
// ----------------------------------------------------------------------------
module rrur_core
  import rrur_pkg::*;
#(
  parameter int SENSOR_COUNT = 3,
  parameter int TIME_WIDTH   = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  tick_t   tick,
  input  cfg_t    cfg,
  output report_t result
);

  localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int PROD_W = TIME_WIDTH + DIST_MUL_W;
  localparam int DCMP_W = PROD_W - DIST_SHIFT;
  localparam int CMP_W  = 33;

  // State
  logic [TIME_WIDTH-1:0] tick_count;
  phase_t                phase_reg;
  logic [SIDX_W-1:0]     active_index;
  logic [TIME_WIDTH-1:0] phase_start;
  logic [SENSOR_COUNT-1:0] echo_prev;
  logic [TIME_WIDTH-1:0] edge_rise_time  [SENSOR_COUNT];
  logic [TIME_WIDTH-1:0] edge_fall_time  [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] echo_complete;
  logic [DIST_W-1:0]     stored_distance [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] reading_valid;
  logic [TIME_WIDTH-1:0] reading_stamp   [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] ever_measured;

  // Next values
  phase_t                phase_next;
  logic [SIDX_W-1:0]     active_next;
  logic [TIME_WIDTH-1:0] start_next;
  logic [SENSOR_COUNT-1:0] levels;
  logic [TIME_WIDTH-1:0] rise_next  [SENSOR_COUNT];
  logic [TIME_WIDTH-1:0] fall_next  [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] complete_next;
  logic [DIST_W-1:0]     dist_next  [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] valid_next;
  logic [TIME_WIDTH-1:0] stamp_next [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] measured_next;

  // Datapath
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] since_start;
  logic [TIME_WIDTH-1:0] act_rise;
  logic [TIME_WIDTH-1:0] act_fall;
  logic [TIME_WIDTH-1:0] duration;
  logic [PROD_W-1:0]     product;
  logic [DCMP_W-1:0]     distance;
  logic                  dist_in_range;
  logic [CMP_W-1:0]      trig_width;
  logic                  trig_done;
  logic                  echo_timed_out;
  logic                  delay_done;
  phase_t                phase_out;
  logic                  trig_phase;

  // Query
  logic                  q_hit;
  logic                  q_valid;
  logic                  q_measured;
  logic [TIME_WIDTH-1:0] q_stamp;
  logic [DIST_W-1:0]     q_dist;
  logic [AGE_W-1:0]      q_age;
  logic                  q_stale;
  logic                  q_usable;

  assign now         = tick_count;
  assign since_start = now - phase_start;
  assign levels      = SENSOR_COUNT'(tick.echo_levels);

  // Edge capture, timestamped with the current tick
  always_comb begin
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      rise_next[s]     = edge_rise_time[s];
      fall_next[s]     = edge_fall_time[s];
      complete_next[s] = echo_complete[s];
      if (levels[s] && !echo_prev[s]) begin
        rise_next[s] = now;
      end else if (!levels[s] && echo_prev[s]) begin
        fall_next[s]     = now;
        complete_next[s] = 1'b1;
      end
    end
  end

  // Pulse width to distance for the active sensor
  assign act_rise      = rise_next[active_index];
  assign act_fall      = fall_next[active_index];
  assign duration      = act_fall - act_rise;
  assign product       = PROD_W'(duration) * PROD_W'(DIST_MUL);
  assign distance      = product[PROD_W-1:DIST_SHIFT];
  assign dist_in_range = (distance >= DCMP_W'(cfg.min_distance_q4)) &&
                         (distance <= DCMP_W'(cfg.max_distance_q4));

  // Phase timing compares
  assign trig_width     = (cfg.trigger_width_us == '0) ? CMP_W'(1)
                                                       : CMP_W'(cfg.trigger_width_us);
  assign trig_done      = (CMP_W'(since_start) + CMP_W'(1)) >= trig_width;
  assign echo_timed_out = CMP_W'(since_start) >= CMP_W'(cfg.echo_timeout_us);
  assign delay_done     = CMP_W'(since_start) >= CMP_W'(cfg.inter_ping_delay_us);

  // Sequencer and reading update
  always_comb begin
    phase_next    = phase_reg;
    active_next   = active_index;
    start_next    = phase_start;
    phase_out     = phase_reg;
    valid_next    = reading_valid;
    measured_next = ever_measured;
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      dist_next[s]  = stored_distance[s];
      stamp_next[s] = reading_stamp[s];
    end

    unique case (phase_reg)
      PH_WAIT: begin
        if (complete_next[active_index]) begin
          if ((act_fall > act_rise) && dist_in_range) begin
            dist_next[active_index]     = distance[DIST_W-1:0];
            stamp_next[active_index]    = now;
            valid_next[active_index]    = 1'b1;
            measured_next[active_index] = 1'b1;
          end else begin
            valid_next[active_index] = 1'b0;
          end
          phase_next = PH_DELAY;
          start_next = now;
        end else if (echo_timed_out) begin
          valid_next[active_index] = 1'b0;
          phase_next = PH_DELAY;
          start_next = now;
        end
      end
      PH_DELAY: begin
        if (delay_done) begin
          if (int'(active_index) == SENSOR_COUNT - 1) begin
            active_next = '0;
          end else begin
            active_next = active_index + SIDX_W'(1);
          end
          phase_next = PH_TRIG;
          start_next = now + TIME_WIDTH'(1);
        end
      end
      default: begin
        phase_out = PH_TRIG;
        if (trig_done) begin
          phase_next = PH_WAIT;
          start_next = now;
        end
      end
    endcase
  end

  assign trig_phase = (phase_out == PH_TRIG);

  // Trigger clears the active sensor's capture, overriding this tick's edge
  logic [TIME_WIDTH-1:0] rise_final [SENSOR_COUNT];
  logic [TIME_WIDTH-1:0] fall_final [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] complete_final;

  always_comb begin
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      if (trig_phase && (int'(active_index) == s)) begin
        rise_final[s]     = '0;
        fall_final[s]     = '0;
        complete_final[s] = 1'b0;
      end else begin
        rise_final[s]     = rise_next[s];
        fall_final[s]     = fall_next[s];
        complete_final[s] = complete_next[s];
      end
    end
  end

  // Query select from the updated readings
  always_comb begin
    q_hit      = 1'b0;
    q_valid    = 1'b0;
    q_measured = 1'b0;
    q_stamp    = '0;
    q_dist     = '0;
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      if (int'(tick.query_sensor) == s) begin
        q_hit      = 1'b1;
        q_valid    = valid_next[s];
        q_measured = measured_next[s];
        q_stamp    = stamp_next[s];
        q_dist     = dist_next[s];
      end
    end
  end

  assign q_age    = (q_hit && q_measured) ? AGE_W'(now - q_stamp) : '1;
  assign q_stale  = !q_hit || (q_age > cfg.stale_timeout_us);
  assign q_usable = q_hit && q_valid && !q_stale;

  // Result fields
  always_comb begin
    for (int b = 0; b < TRIG_W; b++) begin
      result.trigger_lines[b] = trig_phase && (int'(active_index) == b);
    end
    result.active_sensor  = ACT_W'(active_index);
    result.phase          = phase_out;
    result.query_distance = q_usable ? q_dist : '0;
    result.query_usable   = q_usable;
    result.query_age      = q_age;
    result.query_stale    = q_stale;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      phase_reg     <= PH_TRIG;
      active_index  <= '0;
      phase_start   <= '0;
      echo_prev     <= '0;
      echo_complete <= '0;
      reading_valid <= '0;
      ever_measured <= '0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        edge_rise_time[s] <= '0;
        edge_fall_time[s] <= '0;
      end
    end else if (step) begin
      tick_count    <= now + TIME_WIDTH'(1);
      phase_reg     <= phase_next;
      active_index  <= active_next;
      phase_start   <= start_next;
      echo_prev     <= levels;
      echo_complete <= complete_final;
      reading_valid <= valid_next;
      ever_measured <= measured_next;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        edge_rise_time[s] <= rise_final[s];
        edge_fall_time[s] <= fall_final[s];
      end
    end
  end

  // Reading payload, read only behind valid/measured flags
  always_ff @(posedge clk) begin
    if (step) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        stored_distance[s] <= dist_next[s];
        reading_stamp[s]   <= stamp_next[s];
      end
    end
  end

endmodule

@@ rtl/round_robin_ultrasonic_ranger.sv @@
// ----------------------------------------------------------------------------
// round_robin_ultrasonic_ranger
// Pings a row of ultrasonic sensors in turn, one tick per microsecond, and
// reports the stored distance, age and usability of a queried sensor.
//
//   Channel   Signals                               Carries
//   tick      tick_valid, tick_ready, tick          echo levels + query index
//   report    report_valid, report_ready, report    one result per tick
//   cfg       cfg_valid, cfg_ready, cfg_index/data  register writes
//
// One tick per cycle sustained while reports are taken; a tick's result
// passes through the input register and then the result register.
// The single state update per tick (capture, 32x9 distance multiply, range
// compare, query) sits between the input register and the result register.
// Reset (rst, synchronous) clears sequencer, captures and reading flags;
// no clearing pass is needed.
// A stalled report holds the pipeline; the input register keeps taking
// ticks while it is empty.
// ----------------------------------------------------------------------------
module round_robin_ultrasonic_ranger
  import rrur_pkg::*;
#(
  parameter int SENSOR_COUNT = 3,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_ready,
  input  tick_t                 tick,
  output logic                  report_valid,
  input  logic                  report_ready,
  output report_t               report,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    stage_valid;
  tick_t   stage_tick;
  logic    report_load;
  report_t core_result;

  rrur_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the result register loads when empty or being drained
  assign report_load = stage_valid && (!report_valid || report_ready);
  assign tick_ready  = !stage_valid || report_load;

  rrur_core #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (report_load),
    .tick   (stage_tick),
    .cfg    (cfg),
    .result (core_result)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      report_valid <= 1'b0;
    end else begin
      if (tick_ready) begin
        stage_valid <= tick_valid;
      end
      if (report_load) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      stage_tick <= tick;
    end
    if (report_load) begin
      report <= core_result;
    end
  end

endmodule
